// File: src/epoch_seconds_to_utc_calendar_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the epoch-to-calendar converter
// Implication and next-cycle implication forms, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_UTC_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_UTC_CALENDAR_ASSERT_SVH

// same-cycle implication
`define ES2U_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ES2U_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/es2u_pkg.sv
// ----------------------------------------------------------------------------
// es2u_pkg
// Constants, reciprocals and types shared by the epoch-to-calendar pipeline.
// ----------------------------------------------------------------------------
package es2u_pkg;

  // seconds per day is 128 * 675
  localparam int unsigned D675 = 675;
  localparam logic [17:0] M675 = 18'((64'd1 << 27) / 64'd675);
  localparam logic signed [63:0] E_LIM = 64'sd675 <<< 47;
  localparam logic [63:0] U_BIAS = 64'd675 << 40;

  // days in a 400-year era
  localparam int unsigned D_ERA = 146097;
  localparam logic [14:0] M_ERA = 15'((64'd1 << 32) / 64'd146097);
  localparam logic [41:0] Z_BIAS =
    42'((64'd146097 << 23) - (64'd1 << 40) + 64'd719468);
  localparam logic [25:0] ERA_BIAS = 26'(64'd1 << 23);

  localparam int unsigned D1460 = 1460;
  localparam logic [7:0] M1460 = 8'((64'd1 << 18) / 64'd1460);
  localparam int unsigned D7 = 7;
  localparam logic [15:0] M7 = 16'((64'd1 << 18) / 64'd7);
  localparam int unsigned D365 = 365;
  localparam logic [9:0] M365 = 10'((64'd1 << 18) / 64'd365);
  localparam int unsigned D36524 = 36524;
  localparam int unsigned D146096 = 146096;

  localparam int unsigned D3600 = 3600;
  localparam logic [5:0] M3600 = 6'((64'd1 << 17) / 64'd3600);
  localparam int unsigned D60 = 60;
  localparam logic [6:0] M60 = 7'((64'd1 << 12) / 64'd60);

  localparam int unsigned YEAR_BASE = 1900;

  localparam int CIV_STAGES = 14;
  localparam int TOD_DLY = CIV_STAGES - 3;
  localparam int PIPE_DEPTH = CIV_STAGES + 9;

  typedef struct packed {
    logic signed [35:0] year;
    logic [3:0]         month;
    logic [4:0]         dom;
    logic [2:0]         wd;
    logic [8:0]         doy;
  } date_t;

  // first day of each month, year starting on March 1
  function automatic logic [8:0] march_start(input logic [3:0] mp);
    logic [8:0] v;
    case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

// File: src/es2u_civil.sv
// ----------------------------------------------------------------------------
// es2u_civil
// Pipelined biased day count to year, month, day, weekday and day of year.
// ----------------------------------------------------------------------------
module es2u_civil (
  input  logic              clk,
  input  logic              adv,
  input  logic [41:0]       z_in,
  output es2u_pkg::date_t   date_out
);

  typedef struct packed {
    logic [2:0]         wd;
    logic signed [35:0] era400;
  } carry_t;

  function automatic logic [13:0] est_era(input logic [31:0] x);
    logic [46:0] p;
    p = 47'(x) * 47'(es2u_pkg::M_ERA);
    return p[45:32];
  endfunction

  function automatic logic [31:0] fix_era(input logic [31:0] x, input logic [13:0] q);
    logic [31:0] r;
    r = x - 32'(q) * 32'(es2u_pkg::D_ERA);
    if (r >= 32'(es2u_pkg::D_ERA)) return {q + 14'd1, 18'(r - 32'(es2u_pkg::D_ERA))};
    else return {q, 18'(r)};
  endfunction

  logic [31:0] c1_x_r, c3_x_r, c5_x_r;
  logic [13:0] c1_q_r, c3_q_r, c5_q_r;
  logic [27:0] c1_lo_r;
  logic [17:0] c2_r_r, c4_r_r;
  logic [27:0] c2_lo_r;
  logic [13:0] c3_lo_r, c4_lo_r;
  logic [13:0] c4_q1_r, c5_q1_r;
  logic [17:0] c6_doe_r;
  logic [25:0] c6_era_r;
  logic [31:0] f2_nxt, f4_nxt, f6_nxt;

  logic [17:0] c7_doe_r;
  logic signed [25:0] c7_era_r;
  logic [7:0]  c7_q1460_r;
  logic [15:0] c7_q7_r;
  logic [2:0]  c7_q36_r;
  logic        c7_q146_r;

  logic [17:0] c8_doe_r;
  logic [7:0]  c8_q1460_r;
  logic [2:0]  c8_q36_r;
  logic        c8_q146_r;
  carry_t      cr_r [6];

  logic [17:0] c9_n_r, c9_doe_r;
  logic [17:0] c10_n_r, c10_doe_r;
  logic [9:0]  c10_q_r;
  logic [8:0]  c11_yoe_r;
  logic [17:0] c11_doe_r;
  logic [8:0]  c12_doy_r, c12_yoe_r;
  logic [3:0]  c13_mp_r;
  logic [8:0]  c13_doy_r, c13_yoe_r;
  es2u_pkg::date_t date_r;

  logic [7:0]  q1460_nxt;
  logic [2:0]  wd_nxt;
  logic signed [35:0] era400_nxt;
  logic [9:0]  yoe_nxt;
  logic [8:0]  doy_nxt;
  logic [3:0]  mp_nxt;
  es2u_pkg::date_t date_nxt;

  assign f2_nxt = fix_era(c1_x_r, c1_q_r);
  assign f4_nxt = fix_era(c3_x_r, c3_q_r);
  assign f6_nxt = fix_era(c5_x_r, c5_q_r);

  always_comb begin
    logic [17:0] r18;
    logic [17:0] r7;
    logic [2:0]  t7;
    logic signed [35:0] e36;
    r18 = c7_doe_r - 18'(c7_q1460_r) * 18'(es2u_pkg::D1460);
    q1460_nxt = (r18 >= 18'(es2u_pkg::D1460)) ? c7_q1460_r + 8'd1 : c7_q1460_r;
    r7 = c7_doe_r - 18'(c7_q7_r) * 18'(es2u_pkg::D7);
    t7 = (r7 >= 18'(es2u_pkg::D7)) ? 3'(r7 - 18'(es2u_pkg::D7)) : 3'(r7);
    wd_nxt = (t7 >= 3'd4) ? t7 - 3'd4 : t7 + 3'd3;
    e36 = {{10{c7_era_r[25]}}, c7_era_r};
    era400_nxt = (e36 <<< 8) + (e36 <<< 7) + (e36 <<< 4);
  end

  always_comb begin
    logic [17:0] r;
    r = c10_n_r - 18'(c10_q_r) * 18'(es2u_pkg::D365);
    yoe_nxt = (r >= 18'(es2u_pkg::D365)) ? c10_q_r + 10'd1 : c10_q_r;
  end

  always_comb begin
    logic [1:0]  y100;
    logic [17:0] sub;
    y100 = 2'((c11_yoe_r >= 9'd100) ? 1 : 0) + 2'((c11_yoe_r >= 9'd200) ? 1 : 0)
         + 2'((c11_yoe_r >= 9'd300) ? 1 : 0);
    sub = 18'(c11_yoe_r) * 18'(es2u_pkg::D365) + 18'(c11_yoe_r[8:2]) - 18'(y100);
    doy_nxt = 9'(c11_doe_r - sub);
  end

  always_comb begin
    mp_nxt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (es2u_pkg::march_start(4'(k)) <= c12_doy_r) mp_nxt = mp_nxt + 4'd1;
    end
  end

  always_comb begin
    logic       adj;
    logic [8:0] yv;
    logic       leap;
    adj  = (c13_mp_r >= 4'd10);
    yv   = c13_yoe_r + 9'(adj);
    leap = (yv[1:0] == 2'd0) && !(yv == 9'd100 || yv == 9'd200 || yv == 9'd300);
    date_nxt.year  = cr_r[5].era400 + 36'(c13_yoe_r) + 36'(adj);
    date_nxt.month = adj ? c13_mp_r - 4'd10 : c13_mp_r + 4'd2;
    date_nxt.dom   = 5'(c13_doy_r - es2u_pkg::march_start(c13_mp_r) + 9'd1);
    date_nxt.wd    = cr_r[5].wd;
    date_nxt.doy   = adj ? c13_doy_r - 9'd306 : c13_doy_r + 9'd59 + 9'(leap);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_x_r  <= 32'(z_in[41:28]);
      c1_q_r  <= est_era(32'(z_in[41:28]));
      c1_lo_r <= z_in[27:0];
      // top chunk quotient is always zero, keep the remainder only
      c2_r_r  <= f2_nxt[17:0];
      c2_lo_r <= c1_lo_r;
      c3_x_r  <= {c2_r_r, c2_lo_r[27:14]};
      c3_q_r  <= est_era({c2_r_r, c2_lo_r[27:14]});
      c3_lo_r <= c2_lo_r[13:0];
      c4_r_r  <= f4_nxt[17:0];
      c4_q1_r <= f4_nxt[31:18];
      c4_lo_r <= c3_lo_r;
      c5_x_r  <= {c4_r_r, c4_lo_r};
      c5_q_r  <= est_era({c4_r_r, c4_lo_r});
      c5_q1_r <= c4_q1_r;
      c6_doe_r <= f6_nxt[17:0];
      c6_era_r <= 26'({c5_q1_r, f6_nxt[31:18]});

      c7_doe_r    <= c6_doe_r;
      c7_era_r    <= $signed(c6_era_r - es2u_pkg::ERA_BIAS);
      c7_q1460_r  <= 8'((26'(c6_doe_r) * 26'(es2u_pkg::M1460)) >> 18);
      c7_q7_r     <= 16'((34'(c6_doe_r) * 34'(es2u_pkg::M7)) >> 18);
      c7_q36_r    <= 3'((c6_doe_r >= 18'(es2u_pkg::D36524)) ? 1 : 0)
                   + 3'((c6_doe_r >= 18'(2 * es2u_pkg::D36524)) ? 1 : 0)
                   + 3'((c6_doe_r >= 18'(3 * es2u_pkg::D36524)) ? 1 : 0)
                   + 3'((c6_doe_r >= 18'(es2u_pkg::D146096)) ? 1 : 0);
      c7_q146_r   <= (c6_doe_r == 18'(es2u_pkg::D146096));

      c8_doe_r     <= c7_doe_r;
      c8_q1460_r   <= q1460_nxt;
      c8_q36_r     <= c7_q36_r;
      c8_q146_r    <= c7_q146_r;
      cr_r[0].wd     <= wd_nxt;
      cr_r[0].era400 <= era400_nxt;
      for (int i = 1; i < 6; i++) cr_r[i] <= cr_r[i-1];

      c9_n_r   <= c8_doe_r - 18'(c8_q1460_r) + 18'(c8_q36_r) - 18'(c8_q146_r);
      c9_doe_r <= c8_doe_r;

      c10_n_r   <= c9_n_r;
      c10_doe_r <= c9_doe_r;
      c10_q_r   <= 10'((28'(c9_n_r) * 28'(es2u_pkg::M365)) >> 18);

      c11_yoe_r <= 9'(yoe_nxt);
      c11_doe_r <= c10_doe_r;

      c12_doy_r <= doy_nxt;
      c12_yoe_r <= c11_yoe_r;

      c13_mp_r  <= mp_nxt;
      c13_doy_r <= c12_doy_r;
      c13_yoe_r <= c12_yoe_r;

      date_r <= date_nxt;
    end
  end

  assign date_out = date_r;

endmodule

// File: src/epoch_seconds_to_utc_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar
// Every step from input accept to result is one register stage.
// Throughput: one item per cycle; the whole pipeline holds while out is stalled.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] epoch_seconds
  input  logic        out_tready,
  output logic        out_tvalid,
  // [0] valid_res, [32:1] year_since_1900, [36:33] month, [41:37] day_of_month,
  // [46:42] hour, [52:47] minute, [58:53] second, [61:59] weekday,
  // [70:62] day_of_year, [71] zero
  output logic [71:0] out_tdata
);

  typedef struct packed {
    logic       oor;
    logic [6:0] lo7;
  } side_t;

  typedef struct packed {
    logic       oor;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  function automatic logic [16:0] est675(input logic [26:0] x);
    logic [44:0] p;
    p = 45'(x) * 45'(es2u_pkg::M675);
    return p[43:27];
  endfunction

  function automatic logic [26:0] fix675(input logic [26:0] x, input logic [16:0] q);
    logic [26:0] r;
    r = x - 27'(q) * 27'(es2u_pkg::D675);
    if (r >= 27'(es2u_pkg::D675)) return {q + 17'd1, 10'(r - 27'(es2u_pkg::D675))};
    else return {q, 10'(r)};
  endfunction

  logic adv;
  logic [es2u_pkg::PIPE_DEPTH-1:0] v_r;

  logic signed [63:0] e;
  logic [63:0] u_sum;
  side_t side_nxt;
  side_t side_r [7];

  logic [50:0] s1_u_r;
  logic [26:0] s2_x_r, s4_x_r, s6_x_r;
  logic [16:0] s2_q_r, s4_q_r, s6_q_r;
  logic [33:0] s2_u_r;
  logic [9:0]  s3_r_r, s5_r_r;
  logic [16:0] s3_q2_r, s4_q2_r, s5_q2_r, s6_q2_r, s7_q2_r;
  logic [16:0] s5_q1_r, s6_q1_r, s7_q1_r;
  logic [33:0] s3_u_r;
  logic [16:0] s4_u_r, s5_u_r;
  logic [9:0]  s7_r_r;
  logic [16:0] s7_q0_r;
  logic [26:0] f3_nxt, f5_nxt, f7_nxt;

  logic [41:0] z_r;
  logic [16:0] rem_r;
  logic [5:0]  hq_r;
  logic        oor8_r, oor9_r, oor10_r;
  logic [4:0]  h9_r, h10_r;
  logic [11:0] rs9_r, rs10_r;
  logic [6:0]  mq10_r;
  logic [4:0]  h_nxt;
  logic [11:0] rs_nxt;
  tod_t        tod_nxt;
  tod_t        tod11_r;
  tod_t        tod_d_r [es2u_pkg::TOD_DLY];

  es2u_pkg::date_t civ_date;
  logic signed [35:0] yr;
  logic        res_ok;
  logic [71:0] out_nxt;
  logic [71:0] out_r;

  assign adv       = !v_r[es2u_pkg::PIPE_DEPTH-1] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[es2u_pkg::PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  // split off the low seven bits, then long division by 675 in 17-bit chunks
  assign e = $signed(in_tdata);
  assign u_sum = 64'(e >>> 7) + es2u_pkg::U_BIAS;
  assign side_nxt.oor = (e < -es2u_pkg::E_LIM) || (e >= es2u_pkg::E_LIM);
  assign side_nxt.lo7 = in_tdata[6:0];

  assign f3_nxt = fix675(s2_x_r, s2_q_r);
  assign f5_nxt = fix675(s4_x_r, s4_q_r);
  assign f7_nxt = fix675(s6_x_r, s6_q_r);

  always_comb begin
    logic [16:0] r;
    r = rem_r - 17'(hq_r) * 17'(es2u_pkg::D3600);
    if (r >= 17'(es2u_pkg::D3600)) begin
      h_nxt  = 5'(hq_r + 6'd1);
      rs_nxt = 12'(r - 17'(es2u_pkg::D3600));
    end else begin
      h_nxt  = 5'(hq_r);
      rs_nxt = 12'(r);
    end
  end

  always_comb begin
    logic [11:0] r;
    r = rs10_r - 12'(mq10_r) * 12'(es2u_pkg::D60);
    tod_nxt.oor  = oor10_r;
    tod_nxt.hour = h10_r;
    if (r >= 12'(es2u_pkg::D60)) begin
      tod_nxt.minute = 6'(mq10_r + 7'd1);
      tod_nxt.second = 6'(r - 12'(es2u_pkg::D60));
    end else begin
      tod_nxt.minute = 6'(mq10_r);
      tod_nxt.second = 6'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_u_r    <= u_sum[50:0];
      side_r[0] <= side_nxt;
      for (int i = 1; i < 7; i++) side_r[i] <= side_r[i-1];

      s2_x_r <= 27'(s1_u_r[50:34]);
      s2_q_r <= est675(27'(s1_u_r[50:34]));
      s2_u_r <= s1_u_r[33:0];

      s3_r_r  <= f3_nxt[9:0];
      s3_q2_r <= f3_nxt[26:10];
      s3_u_r  <= s2_u_r;

      s4_x_r  <= {s3_r_r, s3_u_r[33:17]};
      s4_q_r  <= est675({s3_r_r, s3_u_r[33:17]});
      s4_q2_r <= s3_q2_r;
      s4_u_r  <= s3_u_r[16:0];

      s5_r_r  <= f5_nxt[9:0];
      s5_q1_r <= f5_nxt[26:10];
      s5_q2_r <= s4_q2_r;
      s5_u_r  <= s4_u_r;

      s6_x_r  <= {s5_r_r, s5_u_r};
      s6_q_r  <= est675({s5_r_r, s5_u_r});
      s6_q2_r <= s5_q2_r;
      s6_q1_r <= s5_q1_r;

      s7_r_r  <= f7_nxt[9:0];
      s7_q0_r <= f7_nxt[26:10];
      s7_q2_r <= s6_q2_r;
      s7_q1_r <= s6_q1_r;

      z_r    <= 42'({s7_q2_r, s7_q1_r, s7_q0_r}) + es2u_pkg::Z_BIAS;
      rem_r  <= {s7_r_r, side_r[6].lo7};
      hq_r   <= 6'((23'({s7_r_r, side_r[6].lo7}) * 23'(es2u_pkg::M3600)) >> 17);
      oor8_r <= side_r[6].oor;

      h9_r   <= h_nxt;
      rs9_r  <= rs_nxt;
      oor9_r <= oor8_r;

      h10_r   <= h9_r;
      rs10_r  <= rs9_r;
      mq10_r  <= 7'((19'(rs9_r) * 19'(es2u_pkg::M60)) >> 12);
      oor10_r <= oor9_r;

      tod11_r    <= tod_nxt;
      tod_d_r[0] <= tod11_r;
      for (int i = 1; i < es2u_pkg::TOD_DLY; i++) tod_d_r[i] <= tod_d_r[i-1];

      out_r <= out_nxt;
    end
  end

  es2u_civil u_civil (
    .clk      (clk),
    .adv      (adv),
    .z_in     (z_r),
    .date_out (civ_date)
  );

  // drop everything when the input is out of range or the year misses the signed 32-bit range
  assign yr     = civ_date.year - 36'(es2u_pkg::YEAR_BASE);
  assign res_ok = !tod_d_r[es2u_pkg::TOD_DLY-1].oor &&
                  ((yr[35:31] == 5'b00000) || (yr[35:31] == 5'b11111));
  assign out_nxt = res_ok ? {1'b0, civ_date.doy, civ_date.wd,
                             tod_d_r[es2u_pkg::TOD_DLY-1].second,
                             tod_d_r[es2u_pkg::TOD_DLY-1].minute,
                             tod_d_r[es2u_pkg::TOD_DLY-1].hour,
                             civ_date.dom, civ_date.month, yr[31:0], 1'b1}
                          : '0;

  assign out_tvalid = v_r[es2u_pkg::PIPE_DEPTH-1];
  assign out_tdata  = out_r;

endmodule

// File: src/es2u_chk.sv
// ----------------------------------------------------------------------------
// es2u_chk
// Port-level checks for the epoch-to-calendar converter, bound to the top.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_utc_calendar_assert.svh"

module es2u_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic        out_tready,
  input logic        out_tvalid,
  input logic [71:0] out_tdata
);

  logic out_stall;
  logic rest_zero;
  logic fields_ok;

  assign out_stall = out_tvalid && !out_tready;
  assign rest_zero = (out_tdata[71:1] == 71'd0);
  assign fields_ok = (out_tdata[36:33] <= 4'd11) && (out_tdata[41:37] != 5'd0) &&
                     (out_tdata[46:42] <= 5'd23) && (out_tdata[52:47] <= 6'd59) &&
                     (out_tdata[58:53] <= 6'd59) && (out_tdata[61:59] <= 3'd6) &&
                     (out_tdata[70:62] <= 9'd365) && !out_tdata[71];

  `ES2U_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata), "moved")
  `ES2U_ASSERT_IMP(a_in_stall, clk, rst_n, out_stall, !in_tready, "input taken while stalled")
  `ES2U_ASSERT_IMP(a_bad_zero, clk, rst_n, out_tvalid && !out_tdata[0], rest_zero, "not zero")
  `ES2U_ASSERT_IMP(a_ranges, clk, rst_n, out_tvalid && out_tdata[0], fields_ok, "out of range")
  `ES2U_ASSERT_IMP(a_in_known, clk, rst_n, in_tvalid, !$isunknown(in_tdata), "unknown item")

endmodule

bind epoch_seconds_to_utc_calendar es2u_chk u_chk (.*);

// File: bench/epoch_seconds_to_utc_calendar_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calendar breakdown checker
// Watches both streams, works out the UTC calendar fields of every accepted
// epoch item and compares each result item, field by field, in order.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_calendar_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        pad;
    logic [8:0]  doy;
    logic [2:0]  wday;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  mday;
    logic [3:0]  mon;
    logic [31:0] year;
    logic        ok;
  } calendar_t;

  calendar_t calendar_q[$];

  function automatic calendar_t utc_calendar(input logic [63:0] raw);
    longint    e, days, rem, wd, z, era, doe, yoe, y, doy, mp, d, m, yr;
    int        start_n[12];
    int        start_l[12];
    bit        leap;
    calendar_t c;
    start_n = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    start_l = '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};
    e = $signed(raw);
    days = e / 86400;
    rem = e % 86400;
    if (rem < 0) begin
      rem += 86400;
      days -= 1;
    end
    wd = (4 + days) % 7;
    if (wd < 0) wd += 7;
    z = days + 719468;
    era = (z >= 0 ? z : z - 146096) / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    y = yoe + era * 400;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    d = doy - (153 * mp + 2) / 5 + 1;
    m = (mp < 10) ? mp + 3 : mp - 9;
    if (m <= 2) y += 1;
    yr = y - 1900;
    c = '0;
    if (yr > 64'sd2147483647 || yr < -64'sd2147483648) return c;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    c.ok = 1'b1;
    c.year = yr[31:0];
    c.mon = 4'(m - 1);
    c.mday = 5'(d);
    c.hour = 5'(rem / 3600);
    c.min = 6'((rem % 3600) / 60);
    c.sec = 6'(rem % 60);
    c.wday = 3'(wd);
    c.doy = 9'((leap ? start_l[m - 1] : start_n[m - 1]) + d - 1);
    return c;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    calendar_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) calendar_q.push_back(utc_calendar(in_tdata));
      if (out_tvalid && out_tready) begin
        got = calendar_t'(out_tdata);
        if (calendar_q.size() == 0) begin
          report("unexpected item", 1, 0);
        end else begin
          want = calendar_q.pop_front();
          if (got.ok != want.ok) report("valid_res", got.ok, want.ok);
          if (got.year != want.year)
            report("year_since_1900", $signed(got.year), $signed(want.year));
          if (got.mon != want.mon) report("month", got.mon, want.mon);
          if (got.mday != want.mday) report("day_of_month", got.mday, want.mday);
          if (got.hour != want.hour) report("hour", got.hour, want.hour);
          if (got.min != want.min) report("minute", got.min, want.min);
          if (got.sec != want.sec) report("second", got.sec, want.sec);
          if (got.wday != want.wday) report("weekday", got.wday, want.wday);
          if (got.doy != want.doy) report("day_of_year", got.doy, want.doy);
          if (got.pad != 1'b0) report("pad bit", got.pad, 0);
        end
      end
      pending <= calendar_q.size();
    end
  end

endmodule

// File: bench/epoch_seconds_to_utc_calendar_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Epoch to UTC calendar testbench
// Drives directed and random epoch items with random gaps and stalls on both
// streams; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_calendar_tb;

  localparam longint LAST_OK = 64'sd67768036191676799;
  localparam longint FIRST_OK = -64'sd67768040609740800;
  localparam int N_RANDOM = 800;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tready;
  logic        out_tvalid;
  logic [71:0] out_tdata;
  int          fail_count;
  int          pending;
  bit          sending_done;

  epoch_seconds_to_utc_calendar dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  epoch_seconds_to_utc_calendar_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] pick_epoch();
    logic [63:0] r;
    longint      v;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1: v = r;
      2, 3, 4: v = $signed(r[40:0]);
      5, 6: v = $signed(r[56:0]);
      7: v = (r[0] ? LAST_OK : FIRST_OK) + $signed(r[18:1]);
      default: v = $signed(r[33:0]) * 86400 + (r[63] ? 86399 : 0) - longint'(r[62]);
    endcase
    return v;
  endfunction

  task automatic send(input logic [63:0] v, input int gap);
    in_tvalid <= 1'b1;
    in_tdata <= v;
    do @(posedge clk); while (!in_tready);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    longint directed[$];
    directed = '{0, -1, 1, 86399, 86400, -86400, -86401, 59, 3599,
                 64'sh7fffffffffffffff, 64'sh8000000000000000,
                 LAST_OK, LAST_OK + 1, FIRST_OK, FIRST_OK - 1,
                 951782400, 951868800, 4107542399, 4107542400,
                 -2208988800, -62135596800, -62167219200, 253402300799,
                 1709210096, -12219292800};
    sending_done = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send(directed[i], 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 400) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      send(pick_epoch(), i < 60 || (i > 500 && i < 560) ? 0 : pick_gap());
    end
    in_tvalid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    int n;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    repeat (80) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 30) : 0;
      repeat (n) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  initial begin
    wait (sending_done);
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("epoch_seconds_to_utc_calendar_tb passed");
    end else begin
      $display("epoch_seconds_to_utc_calendar_tb failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("epoch_seconds_to_utc_calendar_tb failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/es2u_pkg.sv
src/es2u_civil.sv
src/epoch_seconds_to_utc_calendar.sv
src/es2u_chk.sv
bench/epoch_seconds_to_utc_calendar_checker.sv
bench/epoch_seconds_to_utc_calendar_tb.sv
